### sv/eau_pkg.sv
// ============================================================================
// eau_pkg
// Shared widths, register indexes, fixed-point constants and the types that
// pass between the angle unwrap sequencer, its divider and its state memory.
// ============================================================================
package eau_pkg;

  // field and register widths
  localparam int CH_W       = 2;
  localparam int OFFSET_W   = 12;
  localparam int COUNT_W    = 13;
  localparam int OFFSET_REGS = 4;
  localparam int ANGLE_W    = 15;
  localparam int TICK_W     = 32;
  localparam int TURN_W     = 16;
  localparam int SPEED_W    = 21;
  localparam int POS_W      = 32;
  localparam int DELTA_W    = 17;
  localparam int NUM_W      = 27;
  localparam int PROD_W     = 44;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_TURN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK     = 3'd5;

  // fixed-point constants, angle unit 2^-12 rad
  localparam logic [30:0]                TWO_PI_Q28   = 31'd1686629713;
  localparam logic [ANGLE_W-1:0]         TURN_Q12     = 15'd25736;
  localparam logic signed [DELTA_W-1:0]  TURN_DELTA   = 17'sd25736;
  localparam logic signed [DELTA_W-1:0]  JUMP_Q12     = 17'sd15442;
  localparam logic signed [POS_W-1:0]    TURN_POS     = 32'sd25736;
  localparam logic signed [NUM_W-1:0]    MS_PER_S     = 27'sd1000;
  localparam logic signed [TURN_W-1:0]   TURN_MAX     = 16'sh7FFF;
  localparam logic signed [TURN_W-1:0]   TURN_MIN     = 16'sh8000;
  localparam logic signed [SPEED_W-1:0]  SPEED_MAX    = 21'sh0FFFFF;
  localparam logic signed [SPEED_W-1:0]  SPEED_MIN    = 21'sh100000;

  // divider geometry: remainder/divisor width, quotient bits, step counter
  localparam int DIV_W  = 37;
  localparam int DIV_QW = 20;
  localparam int DIV_CW = 5;

  // per-channel state entry
  typedef struct packed {
    logic [ANGLE_W-1:0]        angle;
    logic [TICK_W-1:0]         tick;
    logic signed [TURN_W-1:0]  turns;
    logic signed [SPEED_W-1:0] speed;
  } st_entry_t;

  // divider request: initial partial remainder, dividend bits still to
  // shift in (left aligned), divisor and number of quotient bits
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem_init;
    logic [DIV_QW-1:0] dq_init;
    logic [DIV_W-1:0]  divisor;
    logic [DIV_CW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quo;
    logic [DIV_W-1:0]  rem;
  } div_rsp_t;

endpackage

### sv/encoder_angle_unwrap_speed.sv
// One item is in flight at a time: a new item is accepted only after the current
// one has left the final state. The wrap, angle and speed passes all run on the
// shared bit-serial divider.
// Reset (synchronous, active low) clears the control state, the state memory
// valid bits and the registers to offsets 0, counts per turn 4096, no invert.
// ============================================================================
// encoder_angle_unwrap_speed
// Multi-turn position and speed from up to four absolute angle sensors, with
// per-channel state kept in a small memory and read, updated and written back
// once per item.
// ============================================================================
module encoder_angle_unwrap_speed #(
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // sample input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [eau_pkg::CH_W-1:0]               in_channel,
  input  logic [SAMPLE_BITS-1:0]                 in_raw_sample,
  input  logic [eau_pkg::TICK_W-1:0]             in_tick_ms,
  // result output
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [eau_pkg::CH_W-1:0]               out_channel_out,
  output logic signed [eau_pkg::POS_W-1:0]       out_position,
  output logic signed [eau_pkg::SPEED_W-1:0]     out_speed,
  output logic                                   out_speed_updated,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [eau_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [eau_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int MAG_W     = (SAMPLE_BITS > eau_pkg::OFFSET_W) ? SAMPLE_BITS : eau_pkg::OFFSET_W;
  localparam int MEM_DEPTH = (CHANNELS < 4) ? CHANNELS : 4;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MOD      = 4'd1;
  localparam logic [3:0] S_MOD_WAIT = 4'd2;
  localparam logic [3:0] S_MUL      = 4'd3;
  localparam logic [3:0] S_ANG      = 4'd4;
  localparam logic [3:0] S_ANG_WAIT = 4'd5;
  localparam logic [3:0] S_DELTA    = 4'd6;
  localparam logic [3:0] S_SPD      = 4'd7;
  localparam logic [3:0] S_SPD_WAIT = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  // configuration registers
  logic [eau_pkg::OFFSET_W-1:0] off_r [eau_pkg::OFFSET_REGS];
  logic [eau_pkg::COUNT_W-1:0]  cpt_r;
  logic [eau_pkg::OFFSET_REGS-1:0] inv_r;

  // control
  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       in_fire;
  logic       ch_ok;
  logic       out_free;
  logic       out_load;

  // item and datapath registers
  logic [eau_pkg::CH_W-1:0]           ch_r;
  logic [SAMPLE_BITS-1:0]             raw_r;
  logic [eau_pkg::TICK_W-1:0]         tick_r;
  logic                               dneg_r;
  logic [eau_pkg::COUNT_W-1:0]        r_r;
  logic [eau_pkg::PROD_W-1:0]         prod_r;
  logic [eau_pkg::ANGLE_W-1:0]        angle_r;
  logic signed [eau_pkg::DELTA_W-1:0] delta_r;
  logic signed [eau_pkg::TURN_W-1:0]  tc_r;
  logic [eau_pkg::TICK_W-1:0]         elapsed_r;
  logic signed [eau_pkg::POS_W-1:0]   pos_r;
  logic                               sneg_r;
  logic signed [eau_pkg::SPEED_W-1:0] speed_r;
  logic                               upd_r;

  // output register
  logic                               out_valid_r;
  logic [eau_pkg::CH_W-1:0]           out_ch_r;
  logic signed [eau_pkg::POS_W-1:0]   out_pos_r;
  logic signed [eau_pkg::SPEED_W-1:0] out_spd_r;
  logic                               out_upd_r;

  // combinational datapath
  logic [eau_pkg::OFFSET_W-1:0]       off_sel;
  logic                               inv_sel;
  logic signed [MAG_W:0]              d_s;
  logic [MAG_W-1:0]                   mag;
  logic [eau_pkg::COUNT_W-1:0]        mod_rem;
  logic [eau_pkg::COUNT_W-1:0]        r_nxt;
  logic [eau_pkg::PROD_W-1:0]         prod_nxt;
  logic signed [eau_pkg::DELTA_W-1:0] delta0;
  logic signed [eau_pkg::DELTA_W-1:0] delta1;
  logic signed [eau_pkg::DELTA_W-1:0] delta_nxt;
  logic signed [eau_pkg::TURN_W-1:0]  tc1;
  logic signed [eau_pkg::TURN_W-1:0]  tc_nxt;
  logic signed [eau_pkg::NUM_W-1:0]   num_s;
  logic [eau_pkg::NUM_W-1:0]          an;
  logic [eau_pkg::TICK_W-1:0]         ad;
  logic [eau_pkg::TICK_W+3:0]         ad16;
  logic [eau_pkg::DIV_W-1:0]          spd_dvd;
  logic signed [eau_pkg::POS_W-1:0]   pos_nxt;
  logic signed [eau_pkg::SPEED_W-1:0] q_s;
  logic signed [eau_pkg::SPEED_W-1:0] speed_div;
  logic signed [eau_pkg::POS_W-1:0]   pos_out;
  logic signed [eau_pkg::SPEED_W-1:0] spd_out;

  eau_pkg::div_req_t  div_req;
  eau_pkg::div_rsp_t  div_rsp;
  eau_pkg::st_entry_t ent;
  eau_pkg::st_entry_t wr_ent;
  logic               mem_we;

  // handshake: one item in flight, the output register decouples the sink
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign ch_ok    = (32'(in_channel) < CHANNELS);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_FIN) && out_free;
  assign mem_we   = out_load;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < eau_pkg::OFFSET_REGS; i++) begin
        off_r[i] <= '0;
      end
      cpt_r <= 13'd4096;
      inv_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        eau_pkg::REG_OFFSET_CH0:      off_r[0] <= cfg_wdata[eau_pkg::OFFSET_W-1:0];
        eau_pkg::REG_OFFSET_CH1:      off_r[1] <= cfg_wdata[eau_pkg::OFFSET_W-1:0];
        eau_pkg::REG_OFFSET_CH2:      off_r[2] <= cfg_wdata[eau_pkg::OFFSET_W-1:0];
        eau_pkg::REG_OFFSET_CH3:      off_r[3] <= cfg_wdata[eau_pkg::OFFSET_W-1:0];
        eau_pkg::REG_COUNTS_PER_TURN: cpt_r    <= cfg_wdata;
        eau_pkg::REG_INVERT_MASK:     inv_r    <= cfg_wdata[eau_pkg::OFFSET_REGS-1:0];
        default: ;
      endcase
    end
  end

  // per-channel state memory
  eau_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (MEM_AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_channel[MEM_AW-1:0]),
    .rd_data (ent),
    .wr_en   (mem_we),
    .wr_addr (ch_r[MEM_AW-1:0]),
    .wr_data (wr_ent)
  );

  assign wr_ent.angle = angle_r;
  assign wr_ent.tick  = tick_r;
  assign wr_ent.turns = tc_r;
  assign wr_ent.speed = speed_r;

  // shared divider
  eau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // offset removal and wrap into one turn
  always_comb begin
    off_sel = off_r[ch_r];
    inv_sel = inv_r[ch_r];
    d_s     = $signed({1'b0, MAG_W'(raw_r)}) - $signed({1'b0, MAG_W'(off_sel)});
    mag     = d_s[MAG_W] ? MAG_W'(-d_s) : d_s[MAG_W-1:0];
    mod_rem = div_rsp.rem[eau_pkg::COUNT_W-1:0];
    r_nxt   = (dneg_r && (mod_rem != '0)) ? (cpt_r - mod_rem) : mod_rem;
    // angle numerator with half-unit rounding term
    prod_nxt = r_r * eau_pkg::TWO_PI_Q28 + (eau_pkg::PROD_W'(cpt_r) << 15);
  end

  // unwrap against the previous angle, saturating turn counter
  always_comb begin
    delta0 = $signed({2'b00, angle_r}) - $signed({2'b00, ent.angle});
    delta1 = delta0;
    tc1    = ent.turns;
    if (delta0 >= eau_pkg::JUMP_Q12) begin
      delta1 = delta0 - eau_pkg::TURN_DELTA;
      if (ent.turns > eau_pkg::TURN_MIN) begin
        tc1 = ent.turns - 16'sd1;
      end
    end
    delta_nxt = delta1;
    tc_nxt    = tc1;
    if (delta1 <= -eau_pkg::JUMP_Q12) begin
      delta_nxt = delta1 + eau_pkg::TURN_DELTA;
      if (tc1 < eau_pkg::TURN_MAX) begin
        tc_nxt = tc1 + 16'sd1;
      end
    end
  end

  // speed operands: round(|delta*1000| / |elapsed*16|), ties away from zero
  always_comb begin
    num_s   = eau_pkg::NUM_W'(delta_r) * eau_pkg::MS_PER_S;
    an      = num_s[eau_pkg::NUM_W-1] ? eau_pkg::NUM_W'(-num_s) : eau_pkg::NUM_W'(num_s);
    ad      = elapsed_r[eau_pkg::TICK_W-1] ? (-elapsed_r) : elapsed_r;
    ad16    = {ad, 4'b0000};
    spd_dvd = eau_pkg::DIV_W'({an, 1'b0}) + eau_pkg::DIV_W'(ad16);
    pos_nxt = $signed(eau_pkg::POS_W'(angle_r)) + eau_pkg::POS_W'(tc_r) * eau_pkg::TURN_POS;
    q_s       = $signed({1'b0, div_rsp.quo});
    speed_div = sneg_r ? -q_s : q_s;
  end

  // divider request per pass
  always_comb begin
    div_req = '0;
    if ((state_r == S_MOD) && (cpt_r != '0)) begin
      div_req.start    = 1'b1;
      div_req.rem_init = '0;
      div_req.dq_init  = eau_pkg::DIV_QW'(mag) << (eau_pkg::DIV_QW - MAG_W);
      div_req.divisor  = eau_pkg::DIV_W'(cpt_r);
      div_req.steps    = eau_pkg::DIV_CW'(MAG_W);
    end else if (state_r == S_ANG) begin
      div_req.start    = 1'b1;
      div_req.rem_init = eau_pkg::DIV_W'(prod_r[eau_pkg::PROD_W-1:31]);
      div_req.dq_init  = {prod_r[30:16], {(eau_pkg::DIV_QW - eau_pkg::ANGLE_W){1'b0}}};
      div_req.divisor  = eau_pkg::DIV_W'(cpt_r);
      div_req.steps    = eau_pkg::DIV_CW'(eau_pkg::ANGLE_W);
    end else if ((state_r == S_SPD) && (elapsed_r != '0)) begin
      div_req.start    = 1'b1;
      div_req.rem_init = eau_pkg::DIV_W'(spd_dvd[eau_pkg::DIV_W-1:eau_pkg::DIV_QW]);
      div_req.dq_init  = spd_dvd[eau_pkg::DIV_QW-1:0];
      div_req.divisor  = {ad16, 1'b0};
      div_req.steps    = eau_pkg::DIV_CW'(eau_pkg::DIV_QW);
    end
  end

  // output sign per invert bit
  always_comb begin
    pos_out = inv_sel ? -pos_r : pos_r;
    if (inv_sel) begin
      spd_out = (speed_r == eau_pkg::SPEED_MIN) ? eau_pkg::SPEED_MAX : -speed_r;
    end else begin
      spd_out = speed_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_fire && ch_ok) state_nxt = S_MOD;
      S_MOD:      state_nxt = (cpt_r == '0) ? S_DELTA : S_MOD_WAIT;
      S_MOD_WAIT: if (div_rsp.done) state_nxt = S_MUL;
      S_MUL:      state_nxt = S_ANG;
      S_ANG:      state_nxt = S_ANG_WAIT;
      S_ANG_WAIT: if (div_rsp.done) state_nxt = S_DELTA;
      S_DELTA:    state_nxt = S_SPD;
      S_SPD:      state_nxt = (elapsed_r == '0) ? S_FIN : S_SPD_WAIT;
      S_SPD_WAIT: if (div_rsp.done) state_nxt = S_FIN;
      S_FIN:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r   <= in_channel;
      raw_r  <= in_raw_sample;
      tick_r <= in_tick_ms;
    end
    case (state_r)
      S_MOD: begin
        dneg_r  <= d_s[MAG_W];
        angle_r <= '0;
      end
      S_MOD_WAIT: if (div_rsp.done) r_r <= r_nxt;
      S_MUL:      prod_r <= prod_nxt;
      S_ANG_WAIT: if (div_rsp.done) angle_r <= div_rsp.quo[eau_pkg::ANGLE_W-1:0];
      S_DELTA: begin
        delta_r   <= delta_nxt;
        tc_r      <= tc_nxt;
        elapsed_r <= tick_r - ent.tick;
      end
      S_SPD: begin
        pos_r   <= pos_nxt;
        sneg_r  <= num_s[eau_pkg::NUM_W-1] ^ elapsed_r[eau_pkg::TICK_W-1];
        speed_r <= ent.speed;
        upd_r   <= 1'b0;
      end
      S_SPD_WAIT: begin
        if (div_rsp.done) begin
          speed_r <= speed_div;
          upd_r   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r  <= ch_r;
      out_pos_r <= pos_out;
      out_spd_r <= spd_out;
      out_upd_r <= upd_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_out   = out_ch_r;
  assign out_position      = out_pos_r;
  assign out_speed         = out_spd_r;
  assign out_speed_updated = out_upd_r;

  // divider results arrive only while a pass is awaited
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_MOD_WAIT || state_r == S_ANG_WAIT ||
                      state_r == S_SPD_WAIT))
    else $error("divider finished outside a wait state");

  // a new result is only loaded from the final state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result loaded outside the final state");

  // scaled angle stays inside one turn
  a_angle_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DELTA) |-> (angle_r < eau_pkg::TURN_Q12))
    else $error("angle beyond one turn");

  // unwrapped step stays below the jump threshold
  a_delta_unwrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPD) |-> (delta_r < eau_pkg::JUMP_Q12 && delta_r > -eau_pkg::JUMP_Q12))
    else $error("unwrapped delta not below jump threshold");

  // write-back closes the item
  a_writeback_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (state_r == S_IDLE))
    else $error("state written back without ending the item");

endmodule

### sv/eau_div.sv
// ============================================================================
// eau_div
// Bit-serial restoring divider, one quotient bit per cycle. Shared by the
// wrap into one turn, the angle scaling and the speed quotient.
// ============================================================================
module eau_div (
  input  logic              clk,
  input  logic              rst_n,
  input  eau_pkg::div_req_t req,
  output eau_pkg::div_rsp_t rsp
);

  logic                       busy_r;
  logic                       done_r;
  logic [eau_pkg::DIV_CW-1:0] cnt_r;
  logic [eau_pkg::DIV_W-1:0]  rem_r;
  logic [eau_pkg::DIV_W-1:0]  rem_nxt;
  logic [eau_pkg::DIV_QW-1:0] dq_r;
  logic [eau_pkg::DIV_QW-1:0] dq_nxt;
  logic [eau_pkg::DIV_W-1:0]  dvs_r;
  logic [eau_pkg::DIV_W:0]    trial;
  logic [eau_pkg::DIV_W:0]    diff;
  logic                       ge;

  // one restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    trial   = {rem_r, dq_r[eau_pkg::DIV_QW-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[eau_pkg::DIV_W-1:0] : trial[eau_pkg::DIV_W-1:0];
    dq_nxt  = {dq_r[eau_pkg::DIV_QW-2:0], ge};
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == eau_pkg::DIV_CW'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - eau_pkg::DIV_CW'(1);
        if (cnt_r == eau_pkg::DIV_CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      dq_r  <= req.dq_init;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = dq_r;
  assign rsp.rem  = rem_r;

endmodule

### sv/eau_mem.sv
// ============================================================================
// eau_mem
// Per-channel state memory: one write port, one registered read port.
// Entries not yet written since reset read as zero through valid bits.
// ============================================================================
module eau_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output eau_pkg::st_entry_t rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  eau_pkg::st_entry_t wr_data
);

  eau_pkg::st_entry_t mem_r [DEPTH];
  eau_pkg::st_entry_t rd_data_r;
  logic [DEPTH-1:0]   valid_r;

  // valid bits stand in for the zero reset of the entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule
